### hw/rtl/phu_pkg.sv
package phu_pkg;

  localparam int SAMPLE_BITS_DEF     = 8;
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS        = 30;
  localparam int PRESCALE_SHIFT      = 24;
  localparam int LEVEL_W             = 8;
  localparam int GROUP_W             = 32;
  localparam int GROUP_PAD_W         = 64;
  localparam int THRESH_W            = 8;
  localparam int CFG_INDEX_W         = 2;
  localparam int OUT_W               = 23;
  localparam int STATUS_W            = 2;
  localparam int IN_DATA_W           = 112;
  localparam int OUT_DATA_W          = 32;
  localparam int MERGE_LAT           = 3;

  localparam logic [OUT_W-1:0] OUT_MAX = 23'h7F_FFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_CONTRAST = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WHITE    = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_VALID  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHADOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FLAT   = 2'd2;

  // Reciprocal of six for the final unwrap: floor(v/6) == (v*RECIP6) >> RECIP6_SHIFT
  // for every v below 2^17.
  localparam int RECIP6_W     = 16;
  localparam int RECIP6_SHIFT = 18;
  localparam logic [RECIP6_W-1:0] RECIP6 = 16'd43691;

  // CORDIC elementary angles in Q0.32 turns.
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051D;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2E;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2F9;
      15: r = 32'h0000_517C;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A2F;
      19: r = 32'h0000_0517;
      20: r = 32'h0000_028B;
      21: r = 32'h0000_0145;
      22: r = 32'h0000_00A2;
      23: r = 32'h0000_0051;
      24: r = 32'h0000_0028;
      25: r = 32'h0000_0014;
      26: r = 32'h0000_000A;
      27: r = 32'h0000_0005;
      28: r = 32'h0000_0002;
      29: r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/phu_lane.sv
module phu_lane
  import phu_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [4*SAMPLE_BITS-1:0]   samples,
  output logic [PHASE_FRAC_BITS-1:0] phase,
  output logic                       flat
);

  localparam int D = SAMPLE_BITS + 1;
  localparam int W = SAMPLE_BITS + 1 + PRESCALE_SHIFT + 2;
  localparam int F = PHASE_FRAC_BITS;

  logic [SAMPLE_BITS-1:0] s1, s2, s3, s4;
  logic signed [D-1:0] dx, dy;
  logic signed [W-1:0] dxw, dyw;

  assign s1 = samples[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign s2 = samples[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign s3 = samples[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign s4 = samples[3*SAMPLE_BITS +: SAMPLE_BITS];
  assign dx = signed'({1'b0, s1}) - signed'({1'b0, s3});
  assign dy = signed'({1'b0, s4}) - signed'({1'b0, s2});
  assign dxw = {{(W-D){dx[D-1]}}, dx};
  assign dyw = {{(W-D){dy[D-1]}}, dy};

  logic signed [W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [W-1:0] y_r [0:CORDIC_STEPS];
  logic [31:0]         z_r [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0] spec_r;
  logic [CORDIC_STEPS:0] flat_r;
  logic [1:0]          code_r [0:CORDIC_STEPS];

  logic [1:0] code_nxt;

  // Axis cases: code counts quarter turns.
  always_comb begin
    if (dy == '0) begin
      code_nxt = (dx > 0) ? 2'd0 : 2'd2;
    end else begin
      code_nxt = (dy > 0) ? 2'd1 : 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= ((dx < 0) ? -dxw : dxw) <<< PRESCALE_SHIFT;
      y_r[0]    <= ((dx < 0) ? -dyw : dyw) <<< PRESCALE_SHIFT;
      z_r[0]    <= (dx < 0) ? 32'h8000_0000 : 32'h0000_0000;
      spec_r[0] <= (dx == '0) || (dy == '0);
      flat_r[0] <= (dx == '0) && (dy == '0);
      code_r[0] <= code_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end
        spec_r[i+1] <= spec_r[i];
        flat_r[i+1] <= flat_r[i];
        code_r[i+1] <= code_r[i];
      end
    end
  end

  logic [31:0] z_rnd;
  logic [F-1:0] phase_r;
  logic flat_out_r;

  assign z_rnd = z_r[CORDIC_STEPS] + (32'd1 << (31 - F));

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec_r[CORDIC_STEPS]) begin
        phase_r <= {code_r[CORDIC_STEPS], {(F-2){1'b0}}};
      end else begin
        phase_r <= z_rnd[31 -: F];
      end
      flat_out_r <= flat_r[CORDIC_STEPS];
    end
  end

  assign phase = phase_r;
  assign flat  = flat_out_r;

endmodule

### hw/rtl/phu_merge.sv
module phu_merge
  import phu_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [PHASE_FRAC_BITS-1:0] p0,
  input  logic [PHASE_FRAC_BITS-1:0] p1,
  input  logic [PHASE_FRAC_BITS-1:0] p2,
  output logic [OUT_W-1:0]           phase
);

  localparam int F    = PHASE_FRAC_BITS;
  localparam int N1_W = F + 5;
  localparam int N2_W = F + 12;
  localparam int V_W  = 12;
  localparam int Q_W  = 11;
  localparam int PH_W = F + 14;

  // Stage 1: heterodyne differences of neighboring frequencies.
  logic [F:0] p12_r, p23_r;
  logic [F-1:0] p0_s1_r, p0_s2_r, p0_s3_r;

  function automatic logic [F:0] hetero(input logic [F-1:0] a, input logic [F-1:0] b);
    logic [F:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a > b) begin
      return d;
    end
    return d + ((F+1)'(1) << F);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p12_r   <= hetero(p0, p1);
      p23_r   <= hetero(p1, p2);
      p0_s1_r <= p0;
    end
  end

  // Stage 2: unwrap the first pair against the equivalent phase (ratio 6).
  logic [F+1:0] p123;
  logic signed [N1_W-1:0] num1, mag1, k1;
  logic signed [N1_W-1:0] pm12_r;

  always_comb begin
    if (p12_r > p23_r) begin
      p123 = {1'b0, p12_r} - {1'b0, p23_r};
    end else begin
      p123 = {1'b0, p12_r} - {1'b0, p23_r} + ((F+2)'(1) << F);
    end
    num1 = N1_W'(p123) * N1_W'(6) - N1_W'(p12_r);
    mag1 = (num1 < 0) ? -num1 : num1;
    k1   = (mag1 + (N1_W'(1) << (F-1))) >>> F;
    if (num1 < 0) begin
      k1 = -k1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm12_r  <= N1_W'(p12_r) + (k1 <<< F);
      p0_s2_r <= p0_s1_r;
    end
  end

  // Stage 3: unwrap the finest phase (ratio 64/6), dividing by six through
  // a reciprocal multiply.
  logic signed [N2_W-1:0] num2, mag2;
  logic [V_W-1:0] v;
  logic [V_W+RECIP6_W-1:0] prod;
  logic signed [Q_W-1:0] q, q_r;

  always_comb begin
    num2 = (N2_W'(pm12_r) <<< 6) - N2_W'(p0_s2_r) * N2_W'(6);
    mag2 = (num2 < 0) ? -num2 : num2;
    v    = V_W'((mag2 + (N2_W'(3) << F)) >>> F);
    prod = (V_W+RECIP6_W)'(v) * (V_W+RECIP6_W)'(RECIP6);
    q    = Q_W'(prod >> RECIP6_SHIFT);
    if (num2 < 0) begin
      q = -q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q;
      p0_s3_r <= p0_s2_r;
    end
  end

  // Recombine and saturate.
  logic signed [PH_W-1:0] ph;

  always_comb begin
    ph = PH_W'({1'b0, p0_s3_r}) + (PH_W'(q_r) <<< F);
    if (ph < 0) begin
      phase = '0;
    end else if (ph > PH_W'(OUT_MAX)) begin
      phase = OUT_MAX;
    end else begin
      phase = ph[OUT_W-1:0];
    end
  end

endmodule

### hw/rtl/phase_shift_heterodyne_unwrap_unit.sv
// Four-step phase-shift, three-frequency heterodyne unwrapping of one pixel per
// transfer. Each input transfer carries white and black levels and three groups
// of four phase-shifted samples; each output transfer carries the absolute phase
// in turns (Q7.16, saturated) and a status: valid, shadow, or degenerate (a group
// whose samples are flat). The block takes one pixel every clock when the output
// side keeps up. A pixel passes through the 30 pipelined CORDIC stages in each
// of the three lanes, then the merge stages and the output register. The whole
// pipeline stalls only when a result sits in the output register and is not
// taken.
module phase_shift_heterodyne_unwrap_unit
  import phu_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]    cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: white_level[7:0], black_level[15:8], phase_group_a[47:16],
  // phase_group_b[79:48], phase_group_c[111:80].
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: unwrapped_phase[22:0], pixel_status[24:23], zero fill.
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  localparam int LANE_LAT = CORDIC_STEPS + 2;
  localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

  // Threshold registers.
  logic [THRESH_W-1:0] contrast_r, white_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r  <= 8'd25;
      white_thr_r <= 8'd102;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTRAST: contrast_r  <= cfg_wdata;
        REG_WHITE:    white_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One global advance: everything moves when the output register is free
  // or its result is being taken in this cycle.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [LEVEL_W-1:0] white, black;
  logic lit;
  assign white = in_tdata[0 +: LEVEL_W];
  assign black = in_tdata[LEVEL_W +: LEVEL_W];
  // Shadow test: white - black > contrast and white > white threshold.
  assign lit = ({2'b00, white} > ({2'b00, black} + {2'b00, contrast_r})) &&
               (white > white_thr_r);

  // Valid and shadow flags follow the pixel down the pipeline.
  logic [PIPE_LAT-1:0] vld_r, lit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lit_r <= {lit_r[PIPE_LAT-2:0], lit};
    end
  end

  // Three CORDIC lanes, one per projection frequency.
  logic [PHASE_FRAC_BITS-1:0] lane_phase [0:2];
  logic [2:0] lane_flat;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [GROUP_PAD_W-1:0] grp;
    assign grp = {{(GROUP_PAD_W-GROUP_W){1'b0}},
                  in_tdata[2*LEVEL_W + g*GROUP_W +: GROUP_W]};
    phu_lane #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .samples (grp[4*SAMPLE_BITS-1:0]),
      .phase   (lane_phase[g]),
      .flat    (lane_flat[g])
    );
  end

  // The flat flags must line up with the merge output.
  logic [MERGE_LAT-1:0] flat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      flat_r <= {flat_r[MERGE_LAT-2:0], |lane_flat};
    end
  end

  logic [OUT_W-1:0] merged_phase;

  phu_merge #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_merge (
    .clk   (clk),
    .en    (en),
    .p0    (lane_phase[0]),
    .p1    (lane_phase[1]),
    .p2    (lane_phase[2]),
    .phase (merged_phase)
  );

  // Output register; shadow takes priority over a flat group.
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_phase_r;
  logic [STATUS_W-1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!lit_r[PIPE_LAT-1]) begin
        out_status_r <= STATUS_SHADOW;
        out_phase_r  <= '0;
      end else if (flat_r[MERGE_LAT-1]) begin
        out_status_r <= STATUS_FLAT;
        out_phase_r  <= '0;
      end else begin
        out_status_r <= STATUS_VALID;
        out_phase_r  <= merged_phase;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_W-STATUS_W){1'b0}}, out_status_r, out_phase_r};

endmodule

### hw/rtl/phu_checker.sv
module phu_checker
  import phu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_W +: STATUS_W] == STATUS_VALID ||
                    out_tdata[OUT_W +: STATUS_W] == STATUS_SHADOW ||
                    out_tdata[OUT_W +: STATUS_W] == STATUS_FLAT))
    else $error("bad pixel status");

  a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OUT_W +: STATUS_W] != STATUS_VALID) |->
      out_tdata[OUT_W-1:0] == '0)
    else $error("phase not zero on shadow or flat pixel");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

endmodule

bind phase_shift_heterodyne_unwrap_unit phu_checker u_phu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
